// File: sv/clamped_segment_point_sampler_macros.svh
// assertion macros for the segment sampler checker
`ifndef CLAMPED_SEGMENT_POINT_SAMPLER_MACROS_SVH
`define CLAMPED_SEGMENT_POINT_SAMPLER_MACROS_SVH

// same-cycle implication
`define CSPS_AST_IMM(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication
`define CSPS_AST_NXT(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

// File: sv/csps_pkg.sv
package csps_pkg;

    localparam int MAX_POINTS = 32;

    localparam int DVD_W  = 64;
    localparam int DVS_W  = 34;
    localparam int RAD_W  = 66;
    localparam int ROOT_W = 33;

    localparam logic [30:0] MIN_SPACING   = 31'd3277;
    localparam logic [32:0] SHORT_SEG     = 33'd7;
    localparam logic [30:0] RST_MAX_LEN   = 31'd655360;
    localparam logic [31:0] RST_GND_OFS   = 32'd0;
    localparam logic [30:0] RST_SPACING   = 31'd65536;
    localparam logic [5:0]  RST_BLOCKS    = 6'd32;

    typedef enum logic [1:0] {
        REG_MAX_LEN = 2'd0,
        REG_GND_OFS = 2'd1,
        REG_SPACING = 2'd2,
        REG_BLOCKS  = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_TARGET = 2'd1,
        KIND_POINT  = 2'd2
    } t_kind;

    typedef struct packed {
        logic signed [31:0] player_x;
        logic signed [31:0] player_y;
        logic signed [31:0] player_z;
        logic signed [31:0] cursor_x;
        logic signed [31:0] cursor_y;
        logic signed [31:0] cursor_z;
    } t_req;

    typedef struct packed {
        t_kind              kind;
        logic [4:0]         point_index;
        logic [5:0]         point_count;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_SQ,
        S_RT_GO,
        S_RT_WAIT,
        S_MLSQ,
        S_CMPC,
        S_CMUL,
        S_CDIV_GO,
        S_CDIV_WAIT,
        S_TGT,
        S_CNT,
        S_EMIT_T,
        S_WAIT_T,
        S_PDIV_GO,
        S_PDIV_WAIT,
        S_PT,
        S_WAIT_P,
        S_FIN
    } t_state;

    function automatic logic signed [35:0] smag(input logic sgn, input logic [33:0] mag);
        logic signed [35:0] m;
        m = $signed({2'b00, mag});
        return sgn ? -m : m;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

// File: sv/csps_div.sv
module csps_div
    import csps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DVD_W-1:0]   i_dvd,
    input  logic [DVS_W-1:0]   i_dvs,
    output logic               o_done,
    output logic [DVD_W-1:0]   o_quo,
    output logic [DVS_W-1:0]   o_rem
);

    logic                r_busy;
    logic [6:0]          r_cnt;
    logic [DVS_W:0]      r_rem;
    logic [DVD_W-1:0]    r_quo;
    logic [DVS_W-1:0]    r_dvs;
    logic                r_done;
    logic [DVS_W:0]      trial;
    logic                ge;

    assign trial  = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
    assign ge     = trial >= {1'b0, r_dvs};
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[DVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dvd;
                r_dvs  <= i_dvs;
            end else if (r_busy) begin
                r_rem <= ge ? (trial - {1'b0, r_dvs}) : trial;
                r_quo <= {r_quo[DVD_W-2:0], ge};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: sv/csps_sqrt.sv
module csps_sqrt
    import csps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [RAD_W-1:0]    i_rad,
    output logic                o_done,
    output logic [ROOT_W-1:0]   o_root
);

    logic                r_busy;
    logic                r_done;
    logic [5:0]          r_cnt;
    logic [RAD_W-1:0]    r_rad;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W+3:0]   cur;
    logic [ROOT_W+3:0]   trial;
    logic                ge;
    logic [ROOT_W+3:0]   diff;

    assign cur    = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = cur >= trial;
    assign diff   = cur - trial;
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem  <= ge ? diff[ROOT_W+1:0] : cur[ROOT_W+1:0];
                r_root <= {r_root[ROOT_W-2:0], ge};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: sv/clamped_segment_point_sampler.sv
// channel  | direction | payload | handshake
// request  | in        | t_req   | i_valid / o_stall
// result   | out       | t_res   | o_valid / i_stall
// config   | in        | 32 bit  | psel / penable / pwrite, pready tied high
//
// a request runs the length check, a clamp of the segment when it is longer than the maximum,
// the point count, the step divisions and then its results one at a time
// divider and square root are iterative, and the sequencer waits for each to finish
// o_stall is high from acceptance until the last result of the request is taken
// a held result stops the sequencer until it is taken
// synchronous active-low reset clears control and sets the config registers to defaults
module clamped_segment_point_sampler
    import csps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  t_req         i_req,
    output logic         o_valid,
    input  logic         i_stall,
    output t_res         o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_state              r_state, n_state;
    logic [30:0]         r_ml;
    logic [31:0]         r_goy;
    logic [30:0]         r_sp;
    logic [5:0]          r_biu;

    logic signed [31:0]  r_px, r_pz;
    logic signed [32:0]  r_sy;
    logic                r_sgn [3];
    logic [32:0]         r_mag [3];
    logic [1:0]          r_k;
    logic [65:0]         r_acc;
    logic [65:0]         r_prod;
    logic [32:0]         r_len, r_seg;
    logic                r_pass;
    logic signed [35:0]  r_tx, r_ty, r_tz;
    logic [4:0]          r_q;
    logic [36:0]         r_sacc;
    logic [32:0]         r_qd [3];
    logic [4:0]          r_rd [3];
    logic [32:0]         r_pq [3];
    logic [4:0]          r_pr [3];
    logic [4:0]          r_i;
    t_res                r_out;
    logic                r_oval;

    logic [32:0]         mul_a, mul_b;
    logic [32:0]         mag_sel;
    logic                div_start, div_done;
    logic                rt_start, rt_done;
    logic [DVD_W-1:0]    div_dvd, div_quo;
    logic [DVS_W-1:0]    div_dvs, div_rem;
    logic [ROOT_W-1:0]   rt_root;
    logic signed [32:0]  dx, dy, dz;
    logic [30:0]         sp_eff;
    logic [5:0]          lim;
    logic                is_zero;
    logic                cfg_wr;
    logic signed [35:0]  base [3];
    logic signed [31:0]  pt_pos [3];

    csps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    csps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rt_start),
        .i_rad   (r_acc),
        .o_done  (rt_done),
        .o_root  (rt_root)
    );

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_oval;
    assign o_res   = r_out;

    assign dx = {i_req.cursor_x[31], i_req.cursor_x} - {i_req.player_x[31], i_req.player_x};
    assign dy = {i_req.cursor_y[31], i_req.cursor_y} - {i_req.player_y[31], i_req.player_y};
    assign dz = {i_req.cursor_z[31], i_req.cursor_z} - {i_req.player_z[31], i_req.player_z};

    assign sp_eff  = (r_sp < MIN_SPACING) ? MIN_SPACING : r_sp;
    assign lim     = (r_biu == 6'd0) ? 6'd1 :
                     ((r_biu > 6'(MAX_POINTS)) ? 6'(MAX_POINTS) : r_biu);
    assign is_zero = (r_mag[0] == '0) && (r_mag[1] == '0) && (r_mag[2] == '0);
    assign mag_sel = (r_k == 2'd3) ? '0 : r_mag[r_k];

    assign base[0] = 36'(r_px);
    assign base[1] = 36'(r_sy);
    assign base[2] = 36'(r_pz);

    always_comb begin
        logic        rnd;
        logic [33:0] rv;
        for (int k = 0; k < 3; k++) begin
            rnd = (r_q != 5'd0) &&
                  (({1'b0, r_pr[k]} + {2'b00, r_q[4:1]}) >= {1'b0, r_q});
            rv  = {1'b0, r_pq[k]} + {33'd0, rnd};
            pt_pos[k] = sat32(base[k] + smag(r_sgn[k], rv));
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAX_LEN: prdata = {1'b0, r_ml};
            REG_GND_OFS: prdata = r_goy;
            REG_SPACING: prdata = {1'b0, r_sp};
            REG_BLOCKS:  prdata = {26'd0, r_biu};
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_valid) n_state = S_CHK;
            S_CHK:       n_state = is_zero ? S_FIN : S_SQ;
            S_SQ:        if (r_k == 2'd3) n_state = S_RT_GO;
            S_RT_GO:     n_state = S_RT_WAIT;
            S_RT_WAIT:   if (rt_done) n_state = r_pass ? S_TGT : S_MLSQ;
            S_MLSQ:      n_state = S_CMPC;
            S_CMPC:      n_state = (r_acc > r_prod) ? S_CMUL : S_TGT;
            S_CMUL:      n_state = S_CDIV_GO;
            S_CDIV_GO:   n_state = S_CDIV_WAIT;
            S_CDIV_WAIT: if (div_done) n_state = (r_k == 2'd2) ? S_SQ : S_CMUL;
            S_TGT:       n_state = (r_seg < SHORT_SEG) ? S_FIN : S_CNT;
            S_CNT: begin
                if (!(({1'b0, r_q} < (lim - 6'd1)) && (r_sacc <= {4'd0, r_seg})))
                    n_state = S_EMIT_T;
            end
            S_EMIT_T:    n_state = S_WAIT_T;
            S_WAIT_T:    if (!i_stall) n_state = (r_q == 5'd0) ? S_PT : S_PDIV_GO;
            S_PDIV_GO:   n_state = S_PDIV_WAIT;
            S_PDIV_WAIT: if (div_done) n_state = (r_k == 2'd2) ? S_PT : S_PDIV_GO;
            S_PT:        n_state = S_WAIT_P;
            S_WAIT_P:    if (!i_stall) n_state = (r_i == r_q) ? S_IDLE : S_PT;
            S_FIN:       if (!i_stall) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_a     = mag_sel;
        mul_b     = mag_sel;
        div_start = 1'b0;
        rt_start  = 1'b0;
        div_dvd   = r_prod[63:0] + {31'd0, 1'b0, r_len[32:1]};
        div_dvs   = {1'b0, r_len};
        case (r_state)
            S_MLSQ: begin
                mul_a = {2'b00, r_ml};
                mul_b = {2'b00, r_ml};
            end
            S_CMUL: begin
                mul_b = {2'b00, r_ml};
            end
            S_CDIV_GO:   div_start = 1'b1;
            S_PDIV_GO: begin
                div_start = 1'b1;
                div_dvd   = {31'd0, mag_sel};
                div_dvs   = {29'd0, r_q};
            end
            S_RT_GO:     rt_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {33'd0, mul_a} * {33'd0, mul_b};
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_ml    <= RST_MAX_LEN;
            r_goy   <= RST_GND_OFS;
            r_sp    <= RST_SPACING;
            r_biu   <= RST_BLOCKS;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_MAX_LEN: r_ml  <= pwdata[30:0];
                    REG_GND_OFS: r_goy <= pwdata;
                    REG_SPACING: r_sp  <= pwdata[30:0];
                    REG_BLOCKS:  r_biu <= pwdata[5:0];
                    default: ;
                endcase
            end
            if (r_oval && !i_stall)
                r_oval <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_px     <= i_req.player_x;
                        r_pz     <= i_req.player_z;
                        r_sy     <= {i_req.player_y[31], i_req.player_y} + {r_goy[31], r_goy};
                        r_sgn[0] <= dx[32];
                        r_sgn[1] <= dy[32];
                        r_sgn[2] <= dz[32];
                        r_mag[0] <= dx[32] ? -dx : dx;
                        r_mag[1] <= dy[32] ? -dy : dy;
                        r_mag[2] <= dz[32] ? -dz : dz;
                        r_pass   <= 1'b0;
                        r_k      <= '0;
                        r_acc    <= '0;
                    end
                end
                S_CHK: begin
                    if (is_zero) begin
                        r_out  <= '{kind: KIND_NONE, point_index: '0, point_count: '0,
                                    pos_x: '0, pos_y: '0, pos_z: '0, last: 1'b1};
                        r_oval <= 1'b1;
                    end
                end
                S_SQ: begin
                    if (r_k != 2'd0)
                        r_acc <= r_acc + r_prod;
                    r_k <= r_k + 2'd1;
                end
                S_RT_WAIT: begin
                    if (rt_done) begin
                        if (r_pass)
                            r_seg <= rt_root;
                        else
                            r_len <= rt_root;
                    end
                end
                S_CMPC: begin
                    r_k <= '0;
                    if (!(r_acc > r_prod))
                        r_seg <= r_len;
                end
                S_CDIV_WAIT: begin
                    if (div_done) begin
                        r_mag[r_k] <= div_quo[32:0];
                        if (r_k == 2'd2) begin
                            r_k    <= '0;
                            r_acc  <= '0;
                            r_pass <= 1'b1;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                S_TGT: begin
                    r_tx   <= base[0] + smag(r_sgn[0], {1'b0, r_mag[0]});
                    r_ty   <= base[1] + smag(r_sgn[1], {1'b0, r_mag[1]});
                    r_tz   <= base[2] + smag(r_sgn[2], {1'b0, r_mag[2]});
                    r_q    <= '0;
                    r_sacc <= {6'd0, sp_eff};
                    if (r_seg < SHORT_SEG) begin
                        r_out  <= '{kind: KIND_TARGET, point_index: '0, point_count: '0,
                                    pos_x: sat32(base[0] + smag(r_sgn[0], {1'b0, r_mag[0]})),
                                    pos_y: sat32(base[1] + smag(r_sgn[1], {1'b0, r_mag[1]})),
                                    pos_z: sat32(base[2] + smag(r_sgn[2], {1'b0, r_mag[2]})),
                                    last: 1'b1};
                        r_oval <= 1'b1;
                    end
                end
                S_CNT: begin
                    if (({1'b0, r_q} < (lim - 6'd1)) && (r_sacc <= {4'd0, r_seg})) begin
                        r_q    <= r_q + 5'd1;
                        r_sacc <= r_sacc + {6'd0, sp_eff};
                    end
                end
                S_EMIT_T: begin
                    r_out  <= '{kind: KIND_TARGET, point_index: '0,
                                point_count: {1'b0, r_q} + 6'd1,
                                pos_x: sat32(r_tx), pos_y: sat32(r_ty), pos_z: sat32(r_tz),
                                last: 1'b0};
                    r_oval <= 1'b1;
                end
                S_WAIT_T: begin
                    r_k <= '0;
                    r_i <= '0;
                    for (int k = 0; k < 3; k++) begin
                        r_pq[k] <= '0;
                        r_pr[k] <= '0;
                        r_qd[k] <= '0;
                        r_rd[k] <= '0;
                    end
                end
                S_PDIV_WAIT: begin
                    if (div_done) begin
                        r_qd[r_k] <= div_quo[32:0];
                        r_rd[r_k] <= div_rem[4:0];
                        r_k       <= r_k + 2'd1;
                    end
                end
                S_PT: begin
                    r_out  <= '{kind: KIND_POINT, point_index: r_i,
                                point_count: {1'b0, r_q} + 6'd1,
                                pos_x: pt_pos[0], pos_y: pt_pos[1], pos_z: pt_pos[2],
                                last: (r_i == r_q)};
                    r_oval <= 1'b1;
                end
                S_WAIT_P: begin
                    if (!i_stall && (r_i != r_q)) begin
                        r_i <= r_i + 5'd1;
                        for (int k = 0; k < 3; k++) begin
                            if (({1'b0, r_pr[k]} + {1'b0, r_rd[k]}) >= {1'b0, r_q}) begin
                                r_pr[k] <= 5'(({1'b0, r_pr[k]} + {1'b0, r_rd[k]})
                                              - {1'b0, r_q});
                                r_pq[k] <= r_pq[k] + r_qd[k] + 33'd1;
                            end else begin
                                r_pr[k] <= r_pr[k] + r_rd[k];
                                r_pq[k] <= r_pq[k] + r_qd[k];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: sv/csps_chk.sv
`include "clamped_segment_point_sampler_macros.svh"

module csps_chk
    import csps_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_res o_res
);

    `CSPS_AST_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_res), "held result changed")
    `CSPS_AST_NXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "not busy after request")
    `CSPS_AST_IMM(a_none, i_clk, i_rst_n, o_valid && (o_res.kind == KIND_NONE), o_res.last && (o_res.point_count == 6'd0), "bad none result")
    `CSPS_AST_IMM(a_idx, i_clk, i_rst_n, o_valid && (o_res.kind == KIND_POINT), o_res.point_index < o_res.point_count, "point index out of range")
    `CSPS_AST_IMM(a_zidx, i_clk, i_rst_n, o_valid && (o_res.kind != KIND_POINT), o_res.point_index == 5'd0, "nonzero index on non-point")

endmodule

bind clamped_segment_point_sampler csps_chk u_csps_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);
